### hdl/quaternion_vector_rotate_top_assert.svh
// ----------------------------------------------------------------------------
// Quaternion vector rotate assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QVR_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quaternion rotate check failed");

// The consequent must hold in the cycle after the antecedent.
`define QVR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quaternion rotate check failed");

`endif

### hdl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotate package
// Shared widths, types, constants and multiply helpers.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int COORD_W    = 16;
   localparam int PROD_W     = 2 * COORD_W;       // 16 x 16 product
   localparam int SUM_W      = PROD_W + 2;        // sum of up to four products
   localparam int WIDE_W     = SUM_W + COORD_W;   // second level product
   localparam int ACC_W      = WIDE_W + 2;        // final three-term sum
   localparam int FRAC_SHIFT = 28;
   localparam int RND_W      = ACC_W - FRAC_SHIFT;
   localparam int ROT_MAX    = 32767;
   localparam int ROT_MIN    = -32768;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [RND_W-1:0]   rnd_type;

   localparam acc_type ROUND_HALF = acc_type'(1) <<< (FRAC_SHIFT - 1);

   function automatic prod_type mul_short(input coord_type a, input coord_type b);
      mul_short = prod_type'(a) * prod_type'(b);
   endfunction

   function automatic wide_type mul_wide(input sum_type a, input coord_type b);
      mul_wide = wide_type'(a) * wide_type'(b);
   endfunction

endpackage

### hdl/qvr_req_if.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotate request channel
// Valid/ready channel carrying one point and one quaternion.
// ----------------------------------------------------------------------------
interface qvr_req_if
   import qvr_pkg::*;
   ();
   logic      valid;
   logic      ready;
   coord_type vec_x;
   coord_type vec_y;
   coord_type vec_z;
   coord_type quat_w;
   coord_type quat_x;
   coord_type quat_y;
   coord_type quat_z;

   modport source (output valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
                   input ready);
   modport sink (input valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
                 output ready);
endinterface

### hdl/qvr_rsp_if.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotate response channel
// Valid/ready channel carrying one rotated point and its saturation flag.
// ----------------------------------------------------------------------------
interface qvr_rsp_if
   import qvr_pkg::*;
   ();
   logic      valid;
   logic      ready;
   coord_type rot_x;
   coord_type rot_y;
   coord_type rot_z;
   logic      clipped;

   modport source (output valid, rot_x, rot_y, rot_z, clipped, input ready);
   modport sink (input valid, rot_x, rot_y, rot_z, clipped, output ready);
endinterface

### hdl/qvr_round_sat.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotate rounding
// Drops the 28 fraction bits with round-half-up and saturates to 16 bits.
// ----------------------------------------------------------------------------
module qvr_round_sat
   import qvr_pkg::*;
(
   input  acc_type   sum,
   output coord_type rot,
   output logic      clip
);

   acc_type biased;
   rnd_type whole;

   always_comb begin
      biased = sum + ROUND_HALF;
      whole  = biased[ACC_W-1:FRAC_SHIFT];
      if (whole > ROT_MAX) begin
         rot  = coord_type'(ROT_MAX);
         clip = 1'b1;
      end else if (whole < ROT_MIN) begin
         rot  = coord_type'(ROT_MIN);
         clip = 1'b1;
      end else begin
         rot  = whole[COORD_W-1:0];
         clip = 1'b0;
      end
   end

endmodule

### hdl/quaternion_vector_rotate_top.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotate
// Rotates a signed 16-bit point by a Q1.14 quaternion, computing
// 2(u.v)u + (s^2 - u.u)v + 2s(u x v) exactly, then rounding half up by 2^28
// and saturating to 16 bits; clipped flags any saturated component. The
// block is a five-stage pipeline: 16x16 products, first sums, 34x16
// products, final sum, rounding into the output register. It takes one item
// per clock while ready is high; a result passes through each stage register
// in order before it is valid at the output. Each stage holds its item only
// while the stage after it is full and stalled, so empty slots close up under
// back-pressure and the input drops ready only when all five stages hold
// items and the output is stalled. The quaternion is not normalized.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotate_top_assert.svh"

module quaternion_vector_rotate_top
   import qvr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   qvr_req_if.sink    req_chan,
   qvr_rsp_if.source  rsp_chan
);

   logic [5:1] go;

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   logic s1_vld_in, s2_vld_in, s3_vld_in, s4_vld_in, s5_vld_in;

   // Stage 1: all 16x16 products.
   prod_type  s1_uxvx_ff, s1_uyvy_ff, s1_uzvz_ff;
   prod_type  s1_ss_ff, s1_uxux_ff, s1_uyuy_ff, s1_uzuz_ff;
   prod_type  s1_uyvz_ff, s1_uzvy_ff, s1_uzvx_ff, s1_uxvz_ff, s1_uxvy_ff, s1_uyvx_ff;
   coord_type s1_s_ff, s1_ux_ff, s1_uy_ff, s1_uz_ff, s1_vx_ff, s1_vy_ff, s1_vz_ff;

   // Stage 2: dot product, scale term and cross product.
   sum_type   s2_uv_ff, s2_k_ff, s2_cx_ff, s2_cy_ff, s2_cz_ff;
   coord_type s2_s_ff, s2_ux_ff, s2_uy_ff, s2_uz_ff, s2_vx_ff, s2_vy_ff, s2_vz_ff;

   // Stage 3: the nine second-level products.
   wide_type  s3_ax_ff, s3_ay_ff, s3_az_ff;
   wide_type  s3_bx_ff, s3_by_ff, s3_bz_ff;
   wide_type  s3_cx_ff, s3_cy_ff, s3_cz_ff;

   // Stage 4: full-precision sums at scale 2^28.
   acc_type   s4_sx_ff, s4_sy_ff, s4_sz_ff;

   // Stage 5: output register.
   coord_type s5_rx_ff, s5_ry_ff, s5_rz_ff;
   logic      s5_clip_ff;

   coord_type rnd_x, rnd_y, rnd_z;
   logic      clip_x, clip_y, clip_z;

   always_comb begin
      go[5] = !s5_vld_ff || rsp_chan.ready;
      go[4] = !s4_vld_ff || go[5];
      go[3] = !s3_vld_ff || go[4];
      go[2] = !s2_vld_ff || go[3];
      go[1] = !s1_vld_ff || go[2];

      s1_vld_in = go[1] ? req_chan.valid : s1_vld_ff;
      s2_vld_in = go[2] ? s1_vld_ff : s2_vld_ff;
      s3_vld_in = go[3] ? s2_vld_ff : s3_vld_ff;
      s4_vld_in = go[4] ? s3_vld_ff : s4_vld_ff;
      s5_vld_in = go[5] ? s4_vld_ff : s5_vld_ff;
   end

   assign req_chan.ready = go[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
         s4_vld_ff <= s4_vld_in;
         s5_vld_ff <= s5_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go[1]) begin
         s1_uxvx_ff <= mul_short(req_chan.quat_x, req_chan.vec_x);
         s1_uyvy_ff <= mul_short(req_chan.quat_y, req_chan.vec_y);
         s1_uzvz_ff <= mul_short(req_chan.quat_z, req_chan.vec_z);
         s1_ss_ff   <= mul_short(req_chan.quat_w, req_chan.quat_w);
         s1_uxux_ff <= mul_short(req_chan.quat_x, req_chan.quat_x);
         s1_uyuy_ff <= mul_short(req_chan.quat_y, req_chan.quat_y);
         s1_uzuz_ff <= mul_short(req_chan.quat_z, req_chan.quat_z);
         s1_uyvz_ff <= mul_short(req_chan.quat_y, req_chan.vec_z);
         s1_uzvy_ff <= mul_short(req_chan.quat_z, req_chan.vec_y);
         s1_uzvx_ff <= mul_short(req_chan.quat_z, req_chan.vec_x);
         s1_uxvz_ff <= mul_short(req_chan.quat_x, req_chan.vec_z);
         s1_uxvy_ff <= mul_short(req_chan.quat_x, req_chan.vec_y);
         s1_uyvx_ff <= mul_short(req_chan.quat_y, req_chan.vec_x);
         s1_s_ff    <= req_chan.quat_w;
         s1_ux_ff   <= req_chan.quat_x;
         s1_uy_ff   <= req_chan.quat_y;
         s1_uz_ff   <= req_chan.quat_z;
         s1_vx_ff   <= req_chan.vec_x;
         s1_vy_ff   <= req_chan.vec_y;
         s1_vz_ff   <= req_chan.vec_z;
      end
   end

   always_ff @(posedge clock) begin
      if (go[2]) begin
         s2_uv_ff <= sum_type'(s1_uxvx_ff) + sum_type'(s1_uyvy_ff) + sum_type'(s1_uzvz_ff);
         s2_k_ff  <= sum_type'(s1_ss_ff) - sum_type'(s1_uxux_ff)
                     - sum_type'(s1_uyuy_ff) - sum_type'(s1_uzuz_ff);
         s2_cx_ff <= sum_type'(s1_uyvz_ff) - sum_type'(s1_uzvy_ff);
         s2_cy_ff <= sum_type'(s1_uzvx_ff) - sum_type'(s1_uxvz_ff);
         s2_cz_ff <= sum_type'(s1_uxvy_ff) - sum_type'(s1_uyvx_ff);
         s2_s_ff  <= s1_s_ff;
         s2_ux_ff <= s1_ux_ff;
         s2_uy_ff <= s1_uy_ff;
         s2_uz_ff <= s1_uz_ff;
         s2_vx_ff <= s1_vx_ff;
         s2_vy_ff <= s1_vy_ff;
         s2_vz_ff <= s1_vz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go[3]) begin
         s3_ax_ff <= mul_wide(s2_uv_ff, s2_ux_ff);
         s3_ay_ff <= mul_wide(s2_uv_ff, s2_uy_ff);
         s3_az_ff <= mul_wide(s2_uv_ff, s2_uz_ff);
         s3_bx_ff <= mul_wide(s2_k_ff, s2_vx_ff);
         s3_by_ff <= mul_wide(s2_k_ff, s2_vy_ff);
         s3_bz_ff <= mul_wide(s2_k_ff, s2_vz_ff);
         s3_cx_ff <= mul_wide(s2_cx_ff, s2_s_ff);
         s3_cy_ff <= mul_wide(s2_cy_ff, s2_s_ff);
         s3_cz_ff <= mul_wide(s2_cz_ff, s2_s_ff);
      end
   end

   // The doubled terms are shifted left once; the sum stays below 2^50.
   always_ff @(posedge clock) begin
      if (go[4]) begin
         s4_sx_ff <= (acc_type'(s3_ax_ff) <<< 1) + acc_type'(s3_bx_ff)
                     + (acc_type'(s3_cx_ff) <<< 1);
         s4_sy_ff <= (acc_type'(s3_ay_ff) <<< 1) + acc_type'(s3_by_ff)
                     + (acc_type'(s3_cy_ff) <<< 1);
         s4_sz_ff <= (acc_type'(s3_az_ff) <<< 1) + acc_type'(s3_bz_ff)
                     + (acc_type'(s3_cz_ff) <<< 1);
      end
   end

   qvr_round_sat u_round_x (.sum(s4_sx_ff), .rot(rnd_x), .clip(clip_x));
   qvr_round_sat u_round_y (.sum(s4_sy_ff), .rot(rnd_y), .clip(clip_y));
   qvr_round_sat u_round_z (.sum(s4_sz_ff), .rot(rnd_z), .clip(clip_z));

   always_ff @(posedge clock) begin
      if (go[5]) begin
         s5_rx_ff   <= rnd_x;
         s5_ry_ff   <= rnd_y;
         s5_rz_ff   <= rnd_z;
         s5_clip_ff <= clip_x | clip_y | clip_z;
      end
   end

   assign rsp_chan.valid   = s5_vld_ff;
   assign rsp_chan.rot_x   = s5_rx_ff;
   assign rsp_chan.rot_y   = s5_ry_ff;
   assign rsp_chan.rot_z   = s5_rz_ff;
   assign rsp_chan.clipped = s5_clip_ff;

   // The input only stalls once every stage holds an item.
   `QVR_ASSERT_NOW(a_full_when_blocked, clock, reset, !req_chan.ready,
      s1_vld_ff && s2_vld_ff && s3_vld_ff && s4_vld_ff && s5_vld_ff)

   // An input transfer always lands in the first stage.
   `QVR_ASSERT_NEXT(a_accept_lands, clock, reset, req_chan.valid && req_chan.ready,
      s1_vld_ff)

   // A clipped result carries at least one component at a saturation limit.
   `QVR_ASSERT_NOW(a_clip_at_limit, clock, reset, rsp_chan.valid && rsp_chan.clipped,
      (rsp_chan.rot_x == coord_type'(ROT_MAX)) || (rsp_chan.rot_x == coord_type'(ROT_MIN)) ||
      (rsp_chan.rot_y == coord_type'(ROT_MAX)) || (rsp_chan.rot_y == coord_type'(ROT_MIN)) ||
      (rsp_chan.rot_z == coord_type'(ROT_MAX)) || (rsp_chan.rot_z == coord_type'(ROT_MIN)))

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion vector rotate testbench
// Streams points and quaternions through the rotation pipeline under random
// idling on both channels and predicts each rotated point in exact 64-bit
// arithmetic: round half up by 2^28, then saturation to 16 bits. Every result
// is compared field by field against the oldest prediction still pending.
// ----------------------------------------------------------------------------
module tb_top;
   import qvr_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_JOBS  = 400;
   localparam int HOLD_CYCLES  = 100;
   localparam int DRAIN_CYCLES = 20;
   localparam int UNIT_SPAN    = 9459;   // three such squares stay below 2^28

   typedef struct {
      coord_type vec_x;
      coord_type vec_y;
      coord_type vec_z;
      coord_type quat_w;
      coord_type quat_x;
      coord_type quat_y;
      coord_type quat_z;
   } rotation_job_type;

   typedef struct {
      coord_type rot_x;
      coord_type rot_y;
      coord_type rot_z;
      logic      clipped;
   } rotated_point_type;

   class rotation_scoreboard;
      rotated_point_type pending_rotations[$];
      int                errors = 0;

      function coord_type round_saturate(input longint acc, inout logic clip);
         longint r;
         r = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
         if (r > ROT_MAX) begin
            clip = 1'b1;
            return coord_type'(ROT_MAX);
         end
         if (r < ROT_MIN) begin
            clip = 1'b1;
            return coord_type'(ROT_MIN);
         end
         return coord_type'(r);
      endfunction

      function rotated_point_type rotate_point(input rotation_job_type j);
         longint vx, vy, vz, s, ux, uy, uz;
         longint dot_uv, scale, cx, cy, cz;
         rotated_point_type p;
         vx = longint'(j.vec_x);
         vy = longint'(j.vec_y);
         vz = longint'(j.vec_z);
         s  = longint'(j.quat_w);
         ux = longint'(j.quat_x);
         uy = longint'(j.quat_y);
         uz = longint'(j.quat_z);
         dot_uv = ux * vx + uy * vy + uz * vz;
         scale  = s * s - (ux * ux + uy * uy + uz * uz);
         cx = uy * vz - uz * vy;
         cy = uz * vx - ux * vz;
         cz = ux * vy - uy * vx;
         p.clipped = 1'b0;
         p.rot_x = round_saturate(2 * dot_uv * ux + scale * vx + 2 * s * cx, p.clipped);
         p.rot_y = round_saturate(2 * dot_uv * uy + scale * vy + 2 * s * cy, p.clipped);
         p.rot_z = round_saturate(2 * dot_uv * uz + scale * vz + 2 * s * cz, p.clipped);
         return p;
      endfunction

      function void note_job(input rotation_job_type j);
         pending_rotations = {pending_rotations, rotate_point(j)};
      endfunction

      function int pending();
         return pending_rotations.size();
      endfunction

      function void check_result(input rotated_point_type got);
         rotated_point_type want;
         if (pending_rotations.size() == 0) begin
            $error("rotated point arrived with no transfer pending: %0d %0d %0d %0b",
                   got.rot_x, got.rot_y, got.rot_z, got.clipped);
            errors++;
            return;
         end
         want = pending_rotations.pop_front();
         if (got.rot_x !== want.rot_x) begin
            $error("rot_x mismatch: expected %0d, actual %0d", want.rot_x, got.rot_x);
            errors++;
         end
         if (got.rot_y !== want.rot_y) begin
            $error("rot_y mismatch: expected %0d, actual %0d", want.rot_y, got.rot_y);
            errors++;
         end
         if (got.rot_z !== want.rot_z) begin
            $error("rot_z mismatch: expected %0d, actual %0d", want.rot_z, got.rot_z);
            errors++;
         end
         if (got.clipped !== want.clipped) begin
            $error("clipped mismatch: expected %0b, actual %0b", want.clipped, got.clipped);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   qvr_req_if req_chan();
   qvr_rsp_if rsp_chan();

   quaternion_vector_rotate_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rotation_scoreboard rot_board = new();

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // Result side: checks each transfer out, then picks ready for the next cycle.
   initial begin
      int hold_served;
      int hold_left;
      rotated_point_type got;
      hold_served = 0;
      hold_left   = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.rot_x   = rsp_chan.rot_x;
            got.rot_y   = rsp_chan.rot_y;
            got.rot_z   = rsp_chan.rot_z;
            got.clipped = rsp_chan.clipped;
            rot_board.check_result(got);
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   function automatic coord_type signed_in_span(input int span);
      return coord_type'(int'($urandom_range(2 * span)) - span);
   endfunction

   function automatic coord_type random_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return coord_type'($urandom_range(65535));
      end else if (pick < 85) begin
         return signed_in_span(300);
      end else begin
         case ($urandom_range(5))
            0: return coord_type'(ROT_MIN);
            1: return coord_type'(ROT_MIN + 1);
            2: return coord_type'(-1);
            3: return coord_type'(0);
            4: return coord_type'(1);
            default: return coord_type'(ROT_MAX);
         endcase
      end
   endfunction

   function automatic rotation_job_type random_job();
      rotation_job_type j;
      int pick;
      longint rest;
      j.vec_x = random_coord();
      j.vec_y = random_coord();
      j.vec_z = random_coord();
      pick = $urandom_range(99);
      if (pick < 10) begin
         // Raw 16-bit patterns, well outside the Q1.14 unit range.
         j.quat_w = coord_type'($urandom_range(65535));
         j.quat_x = coord_type'($urandom_range(65535));
         j.quat_y = coord_type'($urandom_range(65535));
         j.quat_z = coord_type'($urandom_range(65535));
      end else if (pick < 50) begin
         j.quat_w = signed_in_span(16384);
         j.quat_x = signed_in_span(16384);
         j.quat_y = signed_in_span(16384);
         j.quat_z = signed_in_span(16384);
      end else begin
         // Close to unit length, so that most rotations stay in range.
         j.quat_w = signed_in_span(UNIT_SPAN);
         j.quat_x = signed_in_span(UNIT_SPAN);
         j.quat_y = signed_in_span(UNIT_SPAN);
         rest = (longint'(1) <<< FRAC_SHIFT) - longint'(j.quat_w) * j.quat_w
                - longint'(j.quat_x) * j.quat_x - longint'(j.quat_y) * j.quat_y;
         j.quat_z = coord_type'($rtoi($sqrt(real'(rest))));
         if ($urandom_range(1)) j.quat_z = -j.quat_z;
      end
      return j;
   endfunction

   function automatic rotation_job_type make_job(input int vx, input int vy, input int vz,
                                                 input int qw, input int qx, input int qy,
                                                 input int qz);
      rotation_job_type j;
      j.vec_x  = coord_type'(vx);
      j.vec_y  = coord_type'(vy);
      j.vec_z  = coord_type'(vz);
      j.quat_w = coord_type'(qw);
      j.quat_x = coord_type'(qx);
      j.quat_y = coord_type'(qy);
      j.quat_z = coord_type'(qz);
      return j;
   endfunction

   // Called at a clock edge; returns at the edge where the transfer happens.
   // Each cycle before the offer idles with the chosen percentage.
   task automatic send_job(input rotation_job_type j);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.vec_x  <= j.vec_x;
      req_chan.vec_y  <= j.vec_y;
      req_chan.vec_z  <= j.vec_z;
      req_chan.quat_w <= j.quat_w;
      req_chan.quat_x <= j.quat_x;
      req_chan.quat_y <= j.quat_y;
      req_chan.quat_z <= j.quat_z;
      req_chan.valid  <= 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      rot_board.note_job(j);
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (rot_board.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic send_random_jobs(input int count);
      repeat (count) send_job(random_job());
   endtask

   initial begin
      rotation_job_type directed[$];
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.vec_x  <= '0;
      req_chan.vec_y  <= '0;
      req_chan.vec_z  <= '0;
      req_chan.quat_w <= '0;
      req_chan.quat_x <= '0;
      req_chan.quat_y <= '0;
      req_chan.quat_z <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity, negated identity, a zero quaternion, a quarter turn and the half turns.
      directed = {directed, make_job(1, 2, 3, 16384, 0, 0, 0)};
      directed = {directed, make_job(32767, -32768, 0, 16384, 0, 0, 0)};
      directed = {directed, make_job(-32768, 32767, -1, -16384, 0, 0, 0)};
      directed = {directed, make_job(12345, -1, 32767, 0, 0, 0, 0)};
      directed = {directed, make_job(10000, 0, 0, 11585, 0, 0, 11585)};
      directed = {directed, make_job(100, 200, 300, 0, 16384, 0, 0)};
      directed = {directed, make_job(32767, 32767, 32767, 0, 0, 0, -16384)};
      directed = {directed, make_job(-32768, -32768, -32768, 0, 0, 16384, 0)};
      // Scale 2^26 puts the exact sums on and beside the rounding halfway point.
      directed = {directed, make_job(2, -2, 3, 8192, 0, 0, 0)};
      directed = {directed, make_job(-1, 1, -3, 8192, 0, 0, 0)};
      // Quaternions that are not of unit length, some far outside Q1.14 range.
      directed = {directed, make_job(30000, 30000, 30000, 16384, 16384, 0, 0)};
      directed = {directed, make_job(32767, -32768, 1, 32767, 32767, 32767, 32767)};
      directed = {directed, make_job(-32768, -32768, -32768, -32768, -32768, -32768, -32768)};
      directed = {directed, make_job(-32768, 32767, -32768, 16384, 16384, 16384, 16384)};
      directed = {directed, make_job(0, 0, 0, -16384, -16384, -16384, -16384)};
      directed = {directed, make_job(32767, 32767, 32767, 1, -1, 1, -1)};
      directed = {directed, make_job(1, 1, 1, -32768, 0, 0, 0)};
      directed = {directed, make_job(32767, -1, 0, -32768, 0, 0, 0)};
      directed = {directed, make_job(21845, -21846, 21845, 21845, -21846, 21845, -21846)};
      directed = {directed, make_job(-21846, 21845, -21846, -21846, 21845, -21846, 21845)};
      foreach (directed[i]) send_job(directed[i]);
      wait_for_drain();

      send_idle_pct = 10;
      rsp_stall_pct = 88;
      send_random_jobs(RANDOM_JOBS);
      wait_for_drain();

      send_idle_pct = 88;
      rsp_stall_pct = 10;
      send_random_jobs(RANDOM_JOBS);
      wait_for_drain();

      // The result side holds off while items keep coming, so the pipeline
      // fills and the input stalls.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_requests++;
      send_random_jobs(RANDOM_JOBS);
      wait_for_drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rot_board.errors == 0 && rot_board.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
